// ----- hw/rtl/gtg_pkg.sv -----
// Shared types and constants for the go-to-goal steering block.
// Holds controller/datapath command types, status codes and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package gtg_pkg;

    // Field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int GOAL_W     = 17;
    localparam int GAIN_W     = 16;
    localparam int POS_W      = 16;
    localparam int HEAD_W     = 15;
    localparam int STATUS_W   = 3;
    localparam int DIST_W     = 17;
    localparam int LIN_W      = 20;
    localparam int ANG_W      = 19;

    // Internal widths
    localparam int GUARD_BITS = 8;
    localparam int ANG_FRAC   = 30;
    localparam int XY_W       = 28;
    localparam int Z_W        = 34;
    localparam int MAG_W      = DIST_W + 1;
    localparam int ATAN_IDX_W = 5;

    // Arithmetic constants
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [31:0] HALF_PI_Q30  = 32'sd1686629713;
    localparam int ANG_CMD_MAX = 262143;
    localparam int ANG_CMD_MIN = -262144;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ARENA_LIMIT   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_RUNNING  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ARRIVED  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_CANCELED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_IDLE     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_MAG,
        ST_CMD,
        ST_OUT
    } state_t;

    // Outcome of one tick, decided at the input transfer
    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_REJECT,
        KIND_CANCEL,
        KIND_RUN
    } kind_t;

    typedef struct packed {
        logic                  load;
        logic                  iter;
        logic [ATAN_IDX_W-1:0] step;
        logic                  mag;
        logic                  cmd;
        logic                  load_out;
        kind_t                 kind;
    } dp_cmd_t;

    typedef struct packed {
        logic goal_bad;
        logic arrived;
    } dp_status_t;

    // atan(2^-i) in Q.30
    function automatic logic signed [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:    v = 32'sd843314857;
            5'd1:    v = 32'sd497837829;
            5'd2:    v = 32'sd263043837;
            5'd3:    v = 32'sd133525159;
            5'd4:    v = 32'sd67021687;
            5'd5:    v = 32'sd33543516;
            5'd6:    v = 32'sd16775851;
            5'd7:    v = 32'sd8388437;
            5'd8:    v = 32'sd4194283;
            5'd9:    v = 32'sd2097149;
            5'd10:   v = 32'sd1048576;
            5'd11:   v = 32'sd524288;
            5'd12:   v = 32'sd262144;
            5'd13:   v = 32'sd131072;
            5'd14:   v = 32'sd65536;
            5'd15:   v = 32'sd32768;
            5'd16:   v = 32'sd16384;
            5'd17:   v = 32'sd8192;
            5'd18:   v = 32'sd4096;
            5'd19:   v = 32'sd2048;
            5'd20:   v = 32'sd1024;
            5'd21:   v = 32'sd512;
            5'd22:   v = 32'sd256;
            5'd23:   v = 32'sd128;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/gtg_ctrl.sv -----
// Controller for the go-to-goal steering block: sequences load, CORDIC steps,
// multiplies and the output register; owns the run-finished latch.
// Depends on gtg_pkg.
`timescale 1ns / 1ps

module gtg_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cancel_request,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic                cfg_write,
    input  gtg_pkg::dp_status_t dp_status,
    output gtg_pkg::dp_cmd_t    dp_cmd
);

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

    gtg_pkg::state_t state_reg, state_next;
    gtg_pkg::kind_t  kind_reg, kind_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rf_reg, rf_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             load_out;

    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == gtg_pkg::ST_OUT) && (!out_valid_reg || !out_stall);

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gtg_pkg::ST_IDLE;
            kind_reg      <= gtg_pkg::KIND_IDLE;
            cnt_reg       <= '0;
            rf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            rf_reg        <= rf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            gtg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    priority if (rf_reg)
                    begin
                        kind_next  = gtg_pkg::KIND_IDLE;
                        state_next = gtg_pkg::ST_OUT;
                    end
                    else if (dp_status.goal_bad)
                    begin
                        kind_next  = gtg_pkg::KIND_REJECT;
                        state_next = gtg_pkg::ST_OUT;
                    end
                    else if (cancel_request)
                    begin
                        kind_next  = gtg_pkg::KIND_CANCEL;
                        state_next = gtg_pkg::ST_OUT;
                    end
                    else
                    begin
                        kind_next  = gtg_pkg::KIND_RUN;
                        state_next = gtg_pkg::ST_ITER;
                    end
                end
            end
            gtg_pkg::ST_ITER:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = gtg_pkg::ST_MAG;
                end
            end
            gtg_pkg::ST_MAG:  state_next = gtg_pkg::ST_CMD;
            gtg_pkg::ST_CMD:  state_next = gtg_pkg::ST_OUT;
            gtg_pkg::ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = gtg_pkg::ST_IDLE;
                end
            end
            default:          state_next = gtg_pkg::ST_IDLE;
        endcase

        // Run-finished latch: a register write clears it
        rf_next = rf_reg;
        if (cfg_write)
        begin
            rf_next = 1'b0;
        end
        else if (accept && kind_next == gtg_pkg::KIND_CANCEL)
        begin
            rf_next = 1'b1;
        end
        else if (load_out && kind_reg == gtg_pkg::KIND_RUN && dp_status.arrived)
        begin
            rf_next = 1'b1;
        end

        // Output register occupancy
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Outputs
    always_comb
    begin
        in_stall        = (state_reg != gtg_pkg::ST_IDLE);
        out_valid       = out_valid_reg;
        dp_cmd.load     = accept;
        dp_cmd.iter     = (state_reg == gtg_pkg::ST_ITER);
        dp_cmd.step     = gtg_pkg::ATAN_IDX_W'(cnt_reg);
        dp_cmd.mag      = (state_reg == gtg_pkg::ST_MAG);
        dp_cmd.cmd      = (state_reg == gtg_pkg::ST_CMD);
        dp_cmd.load_out = load_out;
        dp_cmd.kind     = kind_reg;
    end

    // Checks
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == gtg_pkg::ST_ITER || state_reg == gtg_pkg::ST_OUT))
        else $error("accepted tick did not start iteration or output");

    a_iter_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gtg_pkg::ST_ITER && cnt_reg == LAST_STEP) |=>
        state_reg == gtg_pkg::ST_MAG)
        else $error("CORDIC iteration did not end on last step");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result load did not raise out_valid");

    a_cancel_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_write && !rf_reg && !dp_status.goal_bad && cancel_request)
        |=> rf_reg)
        else $error("cancel did not latch run finished");

endmodule

// ----- hw/rtl/gtg_dp.sv -----
// Datapath for the go-to-goal steering block: CORDIC vectoring registers,
// magnitude and command multipliers, saturation and the result register.
// Depends on gtg_pkg.
`timescale 1ns / 1ps

module gtg_dp #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                   clk,
    input  gtg_pkg::dp_cmd_t                       dp_cmd,
    output gtg_pkg::dp_status_t                    dp_status,
    input  logic signed [gtg_pkg::GOAL_W-1:0]      goal_x,
    input  logic signed [gtg_pkg::GOAL_W-1:0]      goal_y,
    input  logic [gtg_pkg::GAIN_W-1:0]             linear_gain,
    input  logic [gtg_pkg::GAIN_W-1:0]             angular_gain,
    input  logic [gtg_pkg::GAIN_W-1:0]             arrive_radius,
    input  logic [gtg_pkg::GAIN_W-1:0]             arena_limit,
    input  logic [gtg_pkg::POS_W-1:0]              pos_x,
    input  logic [gtg_pkg::POS_W-1:0]              pos_y,
    input  logic signed [gtg_pkg::HEAD_W-1:0]      heading,
    output logic [gtg_pkg::STATUS_W-1:0]           status,
    output logic [gtg_pkg::DIST_W-1:0]             remaining_distance,
    output logic [gtg_pkg::LIN_W-1:0]              linear_cmd,
    output logic signed [gtg_pkg::ANG_W-1:0]       angular_cmd,
    output logic [gtg_pkg::POS_W-1:0]              final_x,
    output logic [gtg_pkg::POS_W-1:0]              final_y
);

    localparam int XY_W    = gtg_pkg::XY_W;
    localparam int Z_W     = gtg_pkg::Z_W;
    localparam int MAG_W   = gtg_pkg::MAG_W;
    localparam int D_W     = gtg_pkg::GOAL_W + 1;
    localparam int SH      = gtg_pkg::ANG_FRAC - FRAC_BITS;
    localparam int BEAR_W  = Z_W - SH + 1;
    localparam int DIFF_W  = BEAR_W + 1;
    localparam int ANGP_W  = DIFF_W + gtg_pkg::GAIN_W + 1;
    localparam int LINP_W  = MAG_W + gtg_pkg::GAIN_W + 1;
    localparam int MPROD_W = XY_W + 32;
    localparam int MAG_SH  = gtg_pkg::ANG_FRAC + gtg_pkg::GUARD_BITS;

    localparam logic signed [MPROD_W-1:0] MAG_HALF = MPROD_W'(1) << (MAG_SH - 1);
    localparam logic signed [Z_W-1:0]     Z_HALF   = Z_W'(1) << (SH - 1);
    localparam logic [LINP_W-1:0]         LIN_HALF = LINP_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ANGP_W-1:0]  ANG_HALF = ANGP_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ANGP_W-1:0]  ANG_MAX  = ANGP_W'(gtg_pkg::ANG_CMD_MAX);
    localparam logic signed [ANGP_W-1:0]  ANG_MIN  = ANGP_W'(gtg_pkg::ANG_CMD_MIN);
    localparam logic [gtg_pkg::LIN_W-1:0] LIN_SAT  = '1;
    localparam logic [gtg_pkg::DIST_W-1:0] DIST_SAT = '1;

    // Working registers
    logic signed [XY_W-1:0]            x_reg, y_reg;
    logic signed [Z_W-1:0]             z_reg;
    logic                              zero_reg;
    logic [gtg_pkg::POS_W-1:0]         px_reg, py_reg;
    logic signed [gtg_pkg::HEAD_W-1:0] hd_reg;
    logic [MAG_W-1:0]                  mag_reg;
    logic signed [BEAR_W-1:0]          bear_reg;
    logic [gtg_pkg::LIN_W-1:0]         lin_reg;
    logic signed [gtg_pkg::ANG_W-1:0]  ang_reg;

    // Result registers
    logic [gtg_pkg::STATUS_W-1:0]      status_reg;
    logic [gtg_pkg::DIST_W-1:0]        dist_reg;
    logic [gtg_pkg::LIN_W-1:0]         lin_out_reg;
    logic signed [gtg_pkg::ANG_W-1:0]  ang_out_reg;
    logic [gtg_pkg::POS_W-1:0]         fx_reg, fy_reg;

    logic signed [D_W-1:0]     dx, dy;
    logic signed [XY_W-1:0]    x0, y0, xs, ys;
    logic signed [XY_W-1:0]    x_init, y_init;
    logic signed [Z_W-1:0]     z_init, atan_z, z_rnd;
    logic signed [MPROD_W-1:0] mag_prod, mag_sum;
    logic [LINP_W-1:0]         lin_prod, lin_sum, lin_shr;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [ANGP_W-1:0]  ang_prod, ang_sum, ang_shr;
    logic                      arrived;

    // Goal check against the arena
    assign dp_status.goal_bad =
        (goal_x < 0) || (goal_x > $signed({1'b0, arena_limit})) ||
        (goal_y < 0) || (goal_y > $signed({1'b0, arena_limit}));

    assign arrived           = (mag_reg <= MAG_W'(arrive_radius));
    assign dp_status.arrived = arrived;

    // Offset to goal and quadrant pre-rotation
    always_comb
    begin
        dx = D_W'(goal_x) - $signed(D_W'(pos_x));
        dy = D_W'(goal_y) - $signed(D_W'(pos_y));
        x0 = XY_W'(dx) <<< gtg_pkg::GUARD_BITS;
        y0 = XY_W'(dy) <<< gtg_pkg::GUARD_BITS;
        x_init = x0;
        y_init = y0;
        z_init = '0;
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                x_init = y0;
                y_init = -x0;
                z_init = Z_W'(gtg_pkg::HALF_PI_Q30);
            end
            else
            begin
                x_init = -y0;
                y_init = x0;
                z_init = -Z_W'(gtg_pkg::HALF_PI_Q30);
            end
        end
    end

    // One CORDIC micro-rotation
    assign xs     = x_reg >>> dp_cmd.step;
    assign ys     = y_reg >>> dp_cmd.step;
    assign atan_z = Z_W'(gtg_pkg::atan_q30(dp_cmd.step));

    // Magnitude scale and bearing rounding
    assign mag_prod = x_reg * gtg_pkg::INV_GAIN_Q30;
    assign mag_sum  = mag_prod + MAG_HALF;
    assign z_rnd    = (z_reg + Z_HALF) >>> SH;

    // Command multiplies
    assign lin_prod = LINP_W'(mag_reg) * LINP_W'(linear_gain);
    assign lin_sum  = lin_prod + LIN_HALF;
    assign lin_shr  = lin_sum >> FRAC_BITS;
    assign diff     = DIFF_W'(bear_reg) - DIFF_W'(hd_reg);
    assign ang_prod = diff * $signed({1'b0, angular_gain});
    assign ang_sum  = ang_prod + ANG_HALF;
    assign ang_shr  = ang_sum >>> FRAC_BITS;

    // Working pipeline
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            x_reg    <= x_init;
            y_reg    <= y_init;
            z_reg    <= z_init;
            zero_reg <= (dx == 0) && (dy == 0);
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            hd_reg   <= heading;
        end
        else if (dp_cmd.iter)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_z;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_z;
            end
        end

        if (dp_cmd.mag)
        begin
            mag_reg  <= mag_sum[MAG_SH +: MAG_W];
            bear_reg <= zero_reg ? '0 : z_rnd[BEAR_W-1:0];
        end

        if (dp_cmd.cmd)
        begin
            lin_reg <= (|lin_shr[LINP_W-1:gtg_pkg::LIN_W]) ? LIN_SAT
                                                           : lin_shr[gtg_pkg::LIN_W-1:0];
            priority if (ang_shr > ANG_MAX)
                ang_reg <= ANG_MAX[gtg_pkg::ANG_W-1:0];
            else if (ang_shr < ANG_MIN)
                ang_reg <= ANG_MIN[gtg_pkg::ANG_W-1:0];
            else
                ang_reg <= ang_shr[gtg_pkg::ANG_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_out)
        begin
            dist_reg    <= '0;
            lin_out_reg <= '0;
            ang_out_reg <= '0;
            fx_reg      <= '0;
            fy_reg      <= '0;
            unique case (dp_cmd.kind)
                gtg_pkg::KIND_IDLE:   status_reg <= gtg_pkg::STATUS_IDLE;
                gtg_pkg::KIND_REJECT: status_reg <= gtg_pkg::STATUS_REJECTED;
                gtg_pkg::KIND_CANCEL: status_reg <= gtg_pkg::STATUS_CANCELED;
                gtg_pkg::KIND_RUN:
                begin
                    status_reg  <= arrived ? gtg_pkg::STATUS_ARRIVED
                                           : gtg_pkg::STATUS_RUNNING;
                    dist_reg    <= mag_reg[MAG_W-1] ? DIST_SAT
                                                    : mag_reg[gtg_pkg::DIST_W-1:0];
                    lin_out_reg <= lin_reg;
                    ang_out_reg <= ang_reg;
                    if (arrived)
                    begin
                        fx_reg <= px_reg;
                        fy_reg <= py_reg;
                    end
                end
                default:              status_reg <= gtg_pkg::STATUS_IDLE;
            endcase
        end
    end

    assign status             = status_reg;
    assign remaining_distance = dist_reg;
    assign linear_cmd         = lin_out_reg;
    assign angular_cmd        = ang_out_reg;
    assign final_x            = fx_reg;
    assign final_y            = fy_reg;

endmodule

// ----- hw/rtl/go_to_goal_proportional_steer.sv -----
// Sequencing: a running tick passes the CORDIC steps, then the magnitude, command and
// output states before result valid; an idle, rejected or canceled tick goes to output.
// No new tick is taken until the previous result is loaded into the output register; the
// iterative CORDIC vectoring unit does one micro-rotation per cycle.
// Reset: configuration registers take their defaults, the run-finished latch clears
// and no result is pending.
`timescale 1ns / 1ps

module go_to_goal_proportional_steer #(
    parameter int FRAC_BITS    = 12,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Tick input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gtg_pkg::POS_W-1:0]           pos_x,
    input  logic [gtg_pkg::POS_W-1:0]           pos_y,
    input  logic signed [gtg_pkg::HEAD_W-1:0]   heading,
    input  logic                                cancel_request,
    // Result output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gtg_pkg::STATUS_W-1:0]        status,
    output logic [gtg_pkg::DIST_W-1:0]          remaining_distance,
    output logic [gtg_pkg::LIN_W-1:0]           linear_cmd,
    output logic signed [gtg_pkg::ANG_W-1:0]    angular_cmd,
    output logic [gtg_pkg::POS_W-1:0]           final_x,
    output logic [gtg_pkg::POS_W-1:0]           final_y,
    // Configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gtg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic signed [gtg_pkg::GOAL_W-1:0] goal_x_reg, goal_y_reg;
    logic [gtg_pkg::GAIN_W-1:0]        linear_gain_reg, angular_gain_reg;
    logic [gtg_pkg::GAIN_W-1:0]        arrive_radius_reg, arena_limit_reg;
    logic                              cfg_xfer;
    logic                              cfg_hit;
    gtg_pkg::dp_cmd_t                  dp_cmd;
    gtg_pkg::dp_status_t               dp_status;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_xfer && (cfg_index <= gtg_pkg::REG_ARENA_LIMIT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg        <= '0;
            goal_y_reg        <= '0;
            linear_gain_reg   <= 16'd2048;
            angular_gain_reg  <= 16'd8192;
            arrive_radius_reg <= 16'd410;
            arena_limit_reg   <= 16'd45384;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                gtg_pkg::REG_GOAL_X:        goal_x_reg        <= $signed(cfg_data);
                gtg_pkg::REG_GOAL_Y:        goal_y_reg        <= $signed(cfg_data);
                gtg_pkg::REG_LINEAR_GAIN:   linear_gain_reg   <= cfg_data[15:0];
                gtg_pkg::REG_ANGULAR_GAIN:  angular_gain_reg  <= cfg_data[15:0];
                gtg_pkg::REG_ARRIVE_RADIUS: arrive_radius_reg <= cfg_data[15:0];
                gtg_pkg::REG_ARENA_LIMIT:   arena_limit_reg   <= cfg_data[15:0];
                default:                    ;
            endcase
        end
    end

    gtg_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cancel_request (cancel_request),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cfg_write      (cfg_hit),
        .dp_status      (dp_status),
        .dp_cmd         (dp_cmd)
    );

    gtg_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk                (clk),
        .dp_cmd             (dp_cmd),
        .dp_status          (dp_status),
        .goal_x             (goal_x_reg),
        .goal_y             (goal_y_reg),
        .linear_gain        (linear_gain_reg),
        .angular_gain       (angular_gain_reg),
        .arrive_radius      (arrive_radius_reg),
        .arena_limit        (arena_limit_reg),
        .pos_x              (pos_x),
        .pos_y              (pos_y),
        .heading            (heading),
        .status             (status),
        .remaining_distance (remaining_distance),
        .linear_cmd         (linear_cmd),
        .angular_cmd        (angular_cmd),
        .final_x            (final_x),
        .final_y            (final_y)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the go-to-goal proportional steering block.
// Holds a bit-exact predictor (CORDIC range/bearing, gains, latched outcome) and the checker.
// Depends on gtg_pkg and go_to_goal_proportional_steer.
`timescale 1ns / 1ps

module testbench;
    import gtg_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_TICKS = 800;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    // Predictor arithmetic
    localparam int FRAC_Q      = 12;
    localparam int GUARD_SHIFT = 8;
    localparam int ANGLE_Q     = 30;
    localparam int ROTATIONS   = 16;
    localparam longint INV_K_Q30        = 652032874;
    localparam longint QUARTER_TURN_Q30 = 1686629713;
    localparam longint ATAN_Q30 [ROTATIONS] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768
    };

    // Indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [DIST_W-1:0]        rem_dist;
        logic [LIN_W-1:0]         lin;
        logic signed [ANG_W-1:0]  ang;
        logic [POS_W-1:0]         fx;
        logic [POS_W-1:0]         fy;
    } steer_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TICK,
        ROW_CHECK
    } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
        logic [POS_W-1:0]         px;
        logic [POS_W-1:0]         py;
        logic signed [HEAD_W-1:0] hd;
        logic                     cancel;
        logic [STATUS_W-1:0]      st;
    } plan_row_t;

    localparam int N_PLAN = 37;

    // Directed plan; CHECK rows carry a status whose other fields are zero
    // (final pose equals the tick pose when arrived)
    plan_row_t plan [N_PLAN] = '{
        // pose on the default goal at the origin, then latched idle
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_ARRIVED},
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_IDLE},
        // goal on the arena corner, all four quadrants
        '{ROW_WRITE, REG_GOAL_X, 17'd45384, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_WRITE, REG_GOAL_Y, 17'd45384, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_TICK, REG_GOAL_X, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_TICK, REG_GOAL_X, 17'd0, 16'd65535, 16'd65535, -15'sd12868, 1'b0,
          STATUS_RUNNING},
        '{ROW_TICK, REG_GOAL_X, 17'd0, 16'd65535, 16'd0, 15'sd12868, 1'b0, STATUS_RUNNING},
        // heading beyond pi, used unclamped
        '{ROW_TICK, REG_GOAL_X, 17'd0, 16'd0, 16'd65535, 15'sd16383, 1'b0, STATUS_RUNNING},
        '{ROW_TICK, REG_GOAL_X, 17'd0, 16'd45384, 16'd45380, 15'h4000, 1'b0,
          STATUS_RUNNING},
        // goal one LSB past the arena; reject wins over cancel
        '{ROW_WRITE, REG_ARENA_LIMIT, 17'd45383, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd100, 16'd100, 15'sd0, 1'b0, STATUS_REJECTED},
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd100, 16'd100, 15'sd0, 1'b1, STATUS_REJECTED},
        // negative goals
        '{ROW_WRITE, REG_ARENA_LIMIT, 17'd65535, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_WRITE, REG_GOAL_X, 17'h1FFFF, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd200, 16'd300, 15'sd100, 1'b0, STATUS_REJECTED},
        '{ROW_WRITE, REG_GOAL_X, 17'h10000, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd200, 16'd300, -15'sd100, 1'b0, STATUS_REJECTED},
        // largest gains: linear command saturates high, angular high then low
        '{ROW_WRITE, REG_GOAL_X, 17'd65535, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_WRITE, REG_GOAL_Y, 17'd65535, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_WRITE, REG_LINEAR_GAIN, 17'd65535, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_WRITE, REG_ANGULAR_GAIN, 17'd65535, 16'd0, 16'd0, 15'sd0, 1'b0,
          STATUS_RUNNING},
        '{ROW_TICK, REG_GOAL_X, 17'd0, 16'd0, 16'd0, 15'h4000, 1'b0, STATUS_RUNNING},
        '{ROW_WRITE, REG_GOAL_X, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_WRITE, REG_GOAL_Y, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_TICK, REG_GOAL_X, 17'd0, 16'd65535, 16'd65535, 15'sd16383, 1'b0,
          STATUS_RUNNING},
        // cancel latches; writes past the register list keep the latch
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd500, 16'd500, 15'sd0, 1'b1, STATUS_CANCELED},
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd500, 16'd500, 15'sd0, 1'b0, STATUS_IDLE},
        '{ROW_WRITE, REG_NONE_LO, 17'h1FFFF, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_IDLE},
        '{ROW_WRITE, REG_NONE_HI, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_CHECK, REG_GOAL_X, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b1, STATUS_IDLE},
        // zero radius with pose on goal: zero vector, bearing 0
        '{ROW_WRITE, REG_ARRIVE_RADIUS, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_TICK, REG_GOAL_X, 17'd0, 16'd0, 16'd0, 15'sd12868, 1'b0, STATUS_RUNNING},
        // widest radius, zero gains
        '{ROW_WRITE, REG_ARRIVE_RADIUS, 17'd65535, 16'd0, 16'd0, 15'sd0, 1'b0,
          STATUS_RUNNING},
        '{ROW_WRITE, REG_LINEAR_GAIN, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_WRITE, REG_ANGULAR_GAIN, 17'd0, 16'd0, 16'd0, 15'sd0, 1'b0, STATUS_RUNNING},
        '{ROW_TICK, REG_GOAL_X, 17'd0, 16'd30000, 16'd20000, 15'sd5000, 1'b0,
          STATUS_RUNNING}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [POS_W-1:0]          pos_x;
    logic [POS_W-1:0]          pos_y;
    logic signed [HEAD_W-1:0]  heading;
    logic                      cancel_request;
    logic                      out_valid;
    logic                      out_stall;
    logic [STATUS_W-1:0]       status;
    logic [DIST_W-1:0]         remaining_distance;
    logic [LIN_W-1:0]          linear_cmd;
    logic signed [ANG_W-1:0]   angular_cmd;
    logic [POS_W-1:0]          final_x;
    logic [POS_W-1:0]          final_y;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // Predictor copy of the configuration and the run latch
    longint tgt_x, tgt_y, k_lin, k_ang, reach_radius, field_limit;
    bit     run_done;

    steer_result_t steer_expect [$];
    int            mismatches = 0;
    bit            calm = 0;
    bit            want_hold = 0;

    go_to_goal_proportional_steer dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .pos_x              (pos_x),
        .pos_y              (pos_y),
        .heading            (heading),
        .cancel_request     (cancel_request),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .remaining_distance (remaining_distance),
        .linear_cmd         (linear_cmd),
        .angular_cmd        (angular_cmd),
        .final_x            (final_x),
        .final_y            (final_y),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Round half up, then arithmetic shift
    function automatic longint round_asr(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Vectoring CORDIC: range and bearing, both Q.12
    function automatic void cordic_range_bearing(input longint dx, input longint dy,
                                                 output longint range_q,
                                                 output longint bearing_q);
        longint x, y, z, t, xs, ys;
        int     i;
        x = dx <<< GUARD_SHIFT;
        y = dy <<< GUARD_SHIFT;
        z = 0;
        // left half plane: pre-rotate by a quarter turn
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER_TURN_Q30;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER_TURN_Q30;
            end
        end
        for (i = 0; i < ROTATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q30[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q30[i];
            end
        end
        range_q = round_asr(x * INV_K_Q30, ANGLE_Q + GUARD_SHIFT);
        bearing_q = (dx == 0 && dy == 0) ? 0 : round_asr(z, ANGLE_Q - FRAC_Q);
    endfunction

    function automatic void reset_setting();
        tgt_x        = 0;
        tgt_y        = 0;
        k_lin        = 2048;
        k_ang        = 8192;
        reach_radius = 410;
        field_limit  = 45384;
        run_done     = 0;
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GOAL_X:        tgt_x = $signed(data);
            REG_GOAL_Y:        tgt_y = $signed(data);
            REG_LINEAR_GAIN:   k_lin = data[15:0];
            REG_ANGULAR_GAIN:  k_ang = data[15:0];
            REG_ARRIVE_RADIUS: reach_radius = data[15:0];
            REG_ARENA_LIMIT:   field_limit = data[15:0];
            default:           return;
        endcase
        run_done = 0;
    endfunction

    // One control tick: outcome, commands and latch update
    function automatic steer_result_t predict_steer(input logic [POS_W-1:0] px,
                                                    input logic [POS_W-1:0] py,
                                                    input logic signed [HEAD_W-1:0] hd,
                                                    input logic cancel);
        steer_result_t r;
        longint pxl, pyl, hdl, dist_q, bear, lin, ang, dsat;
        r = '0;
        pxl = px;
        pyl = py;
        hdl = hd;
        if (run_done)
        begin
            r.status = STATUS_IDLE;
            return r;
        end
        if (tgt_x < 0 || tgt_x > field_limit || tgt_y < 0 || tgt_y > field_limit)
        begin
            r.status = STATUS_REJECTED;
            return r;
        end
        if (cancel)
        begin
            r.status = STATUS_CANCELED;
            run_done = 1;
            return r;
        end
        cordic_range_bearing(tgt_x - pxl, tgt_y - pyl, dist_q, bear);
        lin  = clamp_to(round_asr(dist_q * k_lin, FRAC_Q), 0, 1048575);
        ang  = clamp_to(round_asr((bear - hdl) * k_ang, FRAC_Q), -262144, 262143);
        dsat = clamp_to(dist_q, 0, 131071);
        r.status   = STATUS_RUNNING;
        r.rem_dist = dsat[DIST_W-1:0];
        r.lin      = lin[LIN_W-1:0];
        r.ang      = ang[ANG_W-1:0];
        if (dist_q <= reach_radius)
        begin
            r.status = STATUS_ARRIVED;
            r.fx     = px;
            r.fy     = py;
            run_done = 1;
        end
        return r;
    endfunction

    // 16-bit register value with extremes weighted in; top bit is don't-care
    function automatic logic [CFG_DATA_W-1:0] pick_word();
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom);
        case ($urandom_range(9))
            0:       w[15:0] = 16'h0000;
            1:       w[15:0] = 16'hFFFF;
            default: ;
        endcase
        return w;
    endfunction

    // Goal mostly inside the current arena, sometimes negative or anywhere
    function automatic logic [CFG_DATA_W-1:0] pick_goal();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return CFG_DATA_W'($urandom_range(0, int'(field_limit)));
        else if (roll < 92)
            return 17'h10000 | CFG_DATA_W'($urandom_range(65535));
        return CFG_DATA_W'($urandom);
    endfunction

    // Coordinate within a few hundred LSBs of c, clipped to the pose range
    function automatic logic [POS_W-1:0] near_coord(input longint c);
        longint v;
        v = c + longint'($urandom_range(1400)) - 700;
        v = clamp_to(v, 0, 65535);
        return v[POS_W-1:0];
    endfunction

    // Config write, only with nothing in flight
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid = 0;
        while (steer_expect.size() != 0)
            @(negedge clk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_setting(idx, data);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // Offer one tick; valid stays high after the transfer
    task automatic send_tick(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                             input logic signed [HEAD_W-1:0] hd, input logic cancel,
                             input bit use_typed, input steer_result_t typed,
                             output steer_result_t pred);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 34)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        pos_x          = px;
        pos_y          = py;
        heading        = hd;
        cancel_request = cancel;
        in_valid       = 1;
        do
            @(posedge clk);
        while (in_stall);
        pred = predict_steer(px, py, hd, cancel);
        steer_expect.push_back(use_typed ? typed : pred);
    endtask

    task automatic check_result(input steer_result_t want, input steer_result_t got);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.rem_dist !== want.rem_dist)
        begin
            $error("remaining_distance: expected %0d, got %0d", want.rem_dist,
                   got.rem_dist);
            mismatches++;
        end
        if (got.lin !== want.lin)
        begin
            $error("linear_cmd: expected %0d, got %0d", want.lin, got.lin);
            mismatches++;
        end
        if (got.ang !== want.ang)
        begin
            $error("angular_cmd: expected %0d, got %0d", want.ang, got.ang);
            mismatches++;
        end
        if (got.fx !== want.fx)
        begin
            $error("final_x: expected %0d, got %0d", want.fx, got.fx);
            mismatches++;
        end
        if (got.fy !== want.fy)
        begin
            $error("final_y: expected %0d, got %0d", want.fy, got.fy);
            mismatches++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        steer_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status   = status;
            got.rem_dist = remaining_distance;
            got.lin      = linear_cmd;
            got.ang      = angular_cmd;
            got.fx       = final_x;
            got.fy       = final_y;
            if (steer_expect.size() == 0)
            begin
                $error("result with nothing expected, status %0d", status);
                mismatches++;
            end
            else
                check_result(steer_expect.pop_front(), got);
        end
    end

    // Receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        bit hold_done;
        int held;
        hold_done = 0;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (want_hold && !hold_done)
            begin
                out_stall = 1;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                hold_done = 1;
            end
            else
                out_stall = rst_n && !calm && ($urandom_range(99) < 34);
        end
    end

    // Watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("go_to_goal_proportional_steer: mismatch");
        $finish;
    end

    // Stimulus
    initial
    begin
        steer_result_t            typed;
        steer_result_t            pred;
        logic [POS_W-1:0]         px;
        logic [POS_W-1:0]         py;
        logic signed [HEAD_W-1:0] hd;
        logic                     cancel;
        int                       k;
        int                       live_ticks;
        int                       phase;
        int                       n_ticks;
        int                       idle_seen;
        in_valid       = 0;
        pos_x          = '0;
        pos_y          = '0;
        heading        = '0;
        cancel_request = 0;
        cfg_valid      = 0;
        cfg_index      = REG_GOAL_X;
        cfg_data       = '0;
        rst_n          = 0;
        reset_setting();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed plan
        for (k = 0; k < N_PLAN; k++)
        begin
            if (plan[k].kind == ROW_WRITE)
                cfg_write(plan[k].idx, plan[k].data);
            else
            begin
                typed = '0;
                typed.status = plan[k].st;
                if (plan[k].st == STATUS_ARRIVED)
                begin
                    typed.fx = plan[k].px;
                    typed.fy = plan[k].py;
                end
                send_tick(plan[k].px, plan[k].py, plan[k].hd, plan[k].cancel,
                          plan[k].kind == ROW_CHECK, typed, pred);
            end
        end

        // random phases: reprogram, then a run of ticks, cut short once latched idle is seen twice
        live_ticks = 0;
        phase = 0;
        while (live_ticks < RANDOM_TICKS)
        begin
            phase++;
            calm = (phase >= 12 && phase < 20);
            if ($urandom_range(99) < 30)
                cfg_write(REG_ARENA_LIMIT, pick_word());
            cfg_write(REG_GOAL_X, pick_goal());
            cfg_write(REG_GOAL_Y, pick_goal());
            if ($urandom_range(99) < 30)
                cfg_write(REG_LINEAR_GAIN, pick_word());
            if ($urandom_range(99) < 30)
                cfg_write(REG_ANGULAR_GAIN, pick_word());
            if ($urandom_range(99) < 30)
                cfg_write(REG_ARRIVE_RADIUS, ($urandom_range(3) == 0) ? pick_word() :
                          CFG_DATA_W'($urandom_range(2047)));
            if ($urandom_range(99) < 5)
                cfg_write($urandom_range(1) ? REG_NONE_HI : REG_NONE_LO,
                          CFG_DATA_W'($urandom));
            if (phase == 4)
                want_hold = 1;
            n_ticks = $urandom_range(6, 24);
            idle_seen = 0;
            for (k = 0; k < n_ticks && idle_seen < 2; k++)
            begin
                if ($urandom_range(99) < 40)
                begin
                    px = near_coord(tgt_x);
                    py = near_coord(tgt_y);
                end
                else
                begin
                    px = POS_W'($urandom);
                    py = POS_W'($urandom);
                end
                if ($urandom_range(99) < 70)
                    hd = HEAD_W'(int'($urandom_range(25736)) - 12868);
                else
                    hd = HEAD_W'($urandom);
                cancel = ($urandom_range(99) < 4);
                typed = '0;
                send_tick(px, py, hd, cancel, 1'b0, typed, pred);
                if (pred.status == STATUS_IDLE)
                    idle_seen++;
                else
                    live_ticks++;
            end
        end
        calm = 0;

        // drain
        @(negedge clk);
        in_valid = 0;
        while (steer_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("go_to_goal_proportional_steer: match");
        else
            $display("go_to_goal_proportional_steer: mismatch");
        $finish;
    end

endmodule
